@@ hw/rtl/first_use_node_renumbering_core_assert.svh @@
// Assertion macros used by the node renumbering RTL.
`ifndef FIRST_USE_NODE_RENUMBERING_CORE_ASSERT_SVH
`define FIRST_USE_NODE_RENUMBERING_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is high.
`define RNM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while reset is high.
`define RNM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/rnm_pkg.sv @@
// Shared types and constants for the first-use node renumbering core.
`default_nettype none

package rnm_pkg;

   localparam int NODE_W   = 16;          // old and new node index width
   localparam int COUNT_W  = 17;          // used count and range register width
   localparam int ENTRY_W  = NODE_W + 1;  // number table entry: valid bit + new index
   localparam int STATUS_W = 2;

   localparam int DEFAULT_MAX_NODES = 65536;

   localparam logic [COUNT_W-1:0] SOURCE_COUNT_RESET = 17'h10000;

   localparam int ENTRY_VALID_BIT = NODE_W;

   localparam logic OP_REFERENCE = 1'b0;
   localparam logic OP_LOOKUP    = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNNUMBERED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE      = 2'd2;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_RESOLVE
   } rnm_state_type;

   // One access to the single-port number table.
   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [NODE_W-1:0]   addr;
      logic [ENTRY_W-1:0]  wr_data;
   } tbl_req_type;

endpackage

`default_nettype wire

@@ hw/rtl/first_use_node_renumbering_core.sv @@
// Top level of the first-use node renumbering core.
//
// Each item carries an old node index and an op (element reference or lookup)
// and yields one result item: the dense new index, a status (ok, not yet
// numbered, out of range) and the count of nodes numbered so far. Nodes are
// numbered 0, 1, 2, ... in the order an element reference first touches them;
// a lookup never numbers. Indices at or above source_node_count, or beyond the
// table, return out of range and change nothing. Numbers live in a single-port
// synchronous table of min(MAX_NODES, 65536) entries. After reset the core
// sweeps that table to zero, one entry a cycle, and accepts no item until
// the sweep is done; csr writes are taken throughout. The idle state reads an
// item's table entry; the resolve state resolves it and writes the new number
// back through the same port, waiting while an untaken result is held. No new
// item enters until the last leaves resolve. A finished result waits in an
// output register while the next item is read. Write source_node_count only
// while the core is idle; the table is not cleared by such a write.
`default_nettype none

module first_use_node_renumbering_core
   import rnm_pkg::*;
#(
   parameter int MAX_NODES = DEFAULT_MAX_NODES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data,   // source_node_count
   // input items
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [15:0]        req_tdata,     // [15:0] node_index
   input  wire logic               req_tuser,     // [0] op
   // result items
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [39:0]             rsp_tdata,     // [15:0] new_index, [32:16] used_count
   output logic [STATUS_W-1:0]     rsp_tuser      // [1:0] status
);

   logic [COUNT_W-1:0]  src_count_ff;
   tbl_req_type         tbl_req;
   logic [ENTRY_W-1:0]  tbl_rd_data;
   logic [NODE_W-1:0]   new_index;
   logic [COUNT_W-1:0]  used_count;

   // Hold the range register; load on every csr write.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_count_ff <= SOURCE_COUNT_RESET;
      end else if (csr_wr_en) begin
         src_count_ff <= csr_wr_data;
      end
   end

   rnm_table #(
      .MAX_NODES (MAX_NODES)
   ) u_table (
      .clock   (clock),
      .tbl_req (tbl_req),
      .rd_data (tbl_rd_data)
   );

   rnm_ctrl #(
      .MAX_NODES (MAX_NODES)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .source_node_count (src_count_ff),
      .req_valid         (req_tvalid),
      .req_ready         (req_tready),
      .req_op            (req_tuser),
      .req_node_index    (req_tdata[NODE_W-1:0]),
      .rsp_ready         (rsp_tready),
      .rsp_valid         (rsp_tvalid),
      .rsp_new_index     (new_index),
      .rsp_status        (rsp_tuser),
      .rsp_used_count    (used_count),
      .tbl_req           (tbl_req),
      .tbl_rd_data       (tbl_rd_data)
   );

   // Pack the result fields, low bits first, zero pad to whole bytes.
   assign rsp_tdata = {7'b0, used_count, new_index};

endmodule

`default_nettype wire

@@ hw/rtl/rnm_table.sv @@
// Single-port number table with registered read data.
`default_nettype none

module rnm_table
   import rnm_pkg::*;
#(
   parameter int MAX_NODES = DEFAULT_MAX_NODES
) (
   input  wire logic               clock,
   input  wire tbl_req_type        tbl_req,
   output logic [ENTRY_W-1:0]      rd_data
);

   localparam int TABLE_DEPTH = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]  addr;

   assign addr = tbl_req.addr[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[addr] <= tbl_req.wr_data;
      end
      if (tbl_req.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/rnm_ctrl.sv @@
// Sequencer: clears the table, reads, resolves and writes back one item at a time.
`default_nettype none
`include "first_use_node_renumbering_core_assert.svh"

module rnm_ctrl
   import rnm_pkg::*;
#(
   parameter int MAX_NODES = DEFAULT_MAX_NODES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [COUNT_W-1:0]   source_node_count,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_op,
   input  wire logic [NODE_W-1:0]    req_node_index,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic [NODE_W-1:0]         rsp_new_index,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [COUNT_W-1:0]        rsp_used_count,
   output tbl_req_type               tbl_req,
   input  wire logic [ENTRY_W-1:0]   tbl_rd_data
);

   localparam int TABLE_DEPTH = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [COUNT_W-1:0] DEPTH_C  = COUNT_W'(TABLE_DEPTH);
   localparam logic [ADDR_W-1:0]  LAST_ROW = ADDR_W'(TABLE_DEPTH - 1);

   rnm_state_type state_ff, state_in;

   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [COUNT_W-1:0]  next_ff, next_in;
   logic                op_ff, op_in;
   logic [NODE_W-1:0]   idx_ff, idx_in;
   logic                range_ff, range_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_used_ff, rsp_used_in;

   logic                slot_free;
   logic                numbering;
   logic [NODE_W-1:0]   result;
   logic [STATUS_W-1:0] status;

   logic                in_resolve;
   logic                take_number;
   logic                fresh_ref;
   logic                rsp_error;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Resolve the table entry read for the held item.
   always_comb begin
      result    = '0;
      status    = STATUS_OK;
      numbering = 1'b0;
      if (range_ff) begin
         status = STATUS_RANGE;
      end else if (tbl_rd_data[ENTRY_VALID_BIT]) begin
         result = tbl_rd_data[NODE_W-1:0];
      end else if (op_ff == OP_LOOKUP) begin
         status = STATUS_UNNUMBERED;
      end else if (next_ff >= DEPTH_C) begin
         status = STATUS_RANGE;
      end else begin
         result    = next_ff[NODE_W-1:0];
         numbering = 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      next_in       = next_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      range_in      = range_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;
      req_ready     = 1'b0;
      tbl_req       = '0;

      case (state_ff)
         S_CLEAR: begin
            tbl_req.wr_en = 1'b1;
            tbl_req.addr  = NODE_W'(clr_addr_ff);
            clr_addr_in   = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ROW) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // Ready is high throughout this state, so valid alone takes the item.
            req_ready     = 1'b1;
            tbl_req.rd_en = req_valid;
            tbl_req.addr  = req_node_index;
            if (req_valid) begin
               op_in    = req_op;
               idx_in   = req_node_index;
               range_in = ({1'b0, req_node_index} >= source_node_count) ||
                          ({1'b0, req_node_index} >= DEPTH_C);
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            tbl_req.addr    = idx_ff;
            tbl_req.wr_data = {1'b1, next_ff[NODE_W-1:0]};
            if (slot_free) begin
               tbl_req.wr_en = numbering;
               if (numbering) begin
                  next_in = next_ff + 1'b1;
               end
               rsp_valid_in  = 1'b1;
               rsp_index_in  = result;
               rsp_status_in = status;
               rsp_used_in   = numbering ? next_ff + 1'b1 : next_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         next_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         next_ff      <= next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      range_ff      <= range_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_index  = rsp_index_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_used_count = rsp_used_ff;

   assign in_resolve  = (state_ff == S_RESOLVE);
   assign take_number = in_resolve && slot_free && numbering;
   assign fresh_ref   = !range_ff && !tbl_rd_data[ENTRY_VALID_BIT] && (op_ff == OP_REFERENCE);
   assign rsp_error   = rsp_valid_ff && (rsp_status_ff != STATUS_OK);

   `RNM_ASSERT_NOW(a_no_accept_in_clear, state_ff == S_CLEAR, !req_ready, "accept during clear")
   `RNM_ASSERT_NOW(a_write_only_new, in_resolve && tbl_req.wr_en, fresh_ref, "bad table write")
   `RNM_ASSERT_NEXT(a_count_steady, !take_number, $stable(next_ff), "count moved, no new number")
   `RNM_ASSERT_NOW(a_error_zero_index, rsp_error, rsp_index_ff == '0, "index set on error")

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the first-use node renumbering core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rnm_pkg::*;

   // Cycles with no item moving on either side before the run is abandoned.
   // It must outlast the post-reset table sweep.
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int RSP_STALL_CYCLES = 400;
   localparam int ITEMS_PER_PHASE = 240;
   localparam int TABLE_SIZE = DEFAULT_MAX_NODES;
   localparam int RECENT_POOL_MAX = 64;

   typedef struct packed {
      logic              op;
      logic [NODE_W-1:0] node_index;
   } node_ref_type;

   typedef struct packed {
      logic [NODE_W-1:0]   new_index;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  used_count;
   } renum_result_type;

   // DUT connections; every input starts at a known value.
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [15:0]        req_tdata = '0;
   logic               req_tuser = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [39:0]        rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;

   // Node references waiting for the driver, and results still owed by the core.
   node_ref_type      ref_queue[$];
   renum_result_type  expected_numbers[$];
   logic [NODE_W-1:0] recent_nodes[$];

   // Shadow of the core state: assigned numbers, count of numbered nodes, range limit.
   logic [NODE_W-1:0]  new_number_of[int];
   logic [COUNT_W-1:0] numbered_count = '0;
   logic [COUNT_W-1:0] node_count_limit = SOURCE_COUNT_RESET;

   logic req_taken = 1'b0;
   logic idle_on = 1'b1;
   int   stall_ticket = 0;
   int   stall_seen = 0;
   int   stall_left = 0;
   int   quiet_cycles = 0;
   int   error_count = 0;

   first_use_node_renumbering_core uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // Predict the result of one accepted node reference and advance the shadow state.
   function automatic renum_result_type renumber_node(node_ref_type item);
      renum_result_type r;
      r.new_index = '0;
      r.status    = STATUS_OK;
      if ({1'b0, item.node_index} >= node_count_limit ||
          int'(item.node_index) >= TABLE_SIZE) begin
         r.status = STATUS_RANGE;
      end else if (new_number_of.exists(int'(item.node_index))) begin
         r.new_index = new_number_of[int'(item.node_index)];
      end else if (item.op == OP_LOOKUP) begin
         r.status = STATUS_UNNUMBERED;
      end else if (int'(numbered_count) >= TABLE_SIZE) begin
         // count limit: unreachable with 16-bit indices, kept for completeness
         r.status = STATUS_RANGE;
      end else begin
         r.new_index = numbered_count[NODE_W-1:0];
         new_number_of[int'(item.node_index)] = numbered_count[NODE_W-1:0];
         numbered_count = numbered_count + 1'b1;
      end
      r.used_count = numbered_count;
      return r;
   endfunction

   // Pick a node index: mostly nodes already touched, so repeats and
   // successful lookups dominate, some fresh in-range nodes, some raw noise.
   function automatic logic [NODE_W-1:0] pick_node();
      logic [NODE_W-1:0] idx;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60 && recent_nodes.size() != 0) begin
         idx = recent_nodes[$urandom_range(recent_nodes.size() - 1)];
      end else if (roll < 85 && node_count_limit != 0) begin
         idx = NODE_W'($urandom_range(int'(node_count_limit) - 1));
      end else begin
         idx = NODE_W'($urandom);
      end
      recent_nodes.push_back(idx);
      if (recent_nodes.size() > RECENT_POOL_MAX)
         void'(recent_nodes.pop_front());
      return idx;
   endfunction

   task automatic queue_ref(input logic op, input logic [NODE_W-1:0] idx);
      node_ref_type item;
      item.op = op;
      item.node_index = idx;
      ref_queue.push_back(item);
   endtask

   // Hold the sender until every queued item is in and every result is back.
   task automatic drain_results();
      while (ref_queue.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_numbers.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write source_node_count; the shadow follows once the core has taken the write.
   task automatic set_node_count(input logic [COUNT_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      node_count_limit = value;
   endtask

   // Driver: present the next item at the falling edge once the current one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (ref_queue.size() != 0 && !(idle_on && $urandom_range(99) < 6)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= ref_queue[0].node_index;
            req_tuser  <= ref_queue[0].op;
            void'(ref_queue.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus a long hold-off each time one is requested.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_ticket != stall_seen) begin
         stall_seen <= stall_ticket;
         stall_left <= RSP_STALL_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_on && $urandom_range(99) < 6);
      end
   end

   // Monitor: predict on input handshakes, check on output handshakes, run the watchdog.
   always @(posedge clock) begin
      renum_result_type want;
      renum_result_type got;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_numbers.push_back(renumber_node({req_tuser, req_tdata}));
         if (rsp_tvalid && rsp_tready) begin
            got.new_index  = rsp_tdata[15:0];
            got.used_count = rsp_tdata[32:16];
            got.status     = rsp_tuser;
            if (expected_numbers.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("tb: unexpected result new_index=%0d status=%0d used_count=%0d",
                           got.new_index, got.status, got.used_count);
            end else begin
               want = expected_numbers.pop_front();
               if (got.new_index !== want.new_index || got.status !== want.status ||
                   got.used_count !== want.used_count) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("tb: mismatch exp idx=%0d st=%0d cnt=%0d got %0d %0d %0d",
                              want.new_index, want.status, want.used_count,
                              got.new_index, got.status, got.used_count);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   // Stimulus sequence.
   initial begin
      logic [COUNT_W-1:0] phase_limits[7];
      phase_limits = '{17'h10000, 17'd300, 17'd1, 17'd4096, 17'hFFFF, 17'd17, 17'h10000};

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Write the register during the sweep; items wait until the table is clear.
      set_node_count(17'h10000);

      // Directed: first use, repeats, lookups of numbered and unnumbered nodes, extremes.
      queue_ref(OP_LOOKUP, 16'h0000);
      queue_ref(OP_REFERENCE, 16'h0000);
      queue_ref(OP_REFERENCE, 16'h0000);
      queue_ref(OP_LOOKUP, 16'h0000);
      queue_ref(OP_REFERENCE, 16'hFFFF);
      queue_ref(OP_LOOKUP, 16'hFFFF);
      queue_ref(OP_REFERENCE, 16'h5555);
      queue_ref(OP_REFERENCE, 16'hAAAA);
      queue_ref(OP_LOOKUP, 16'h1234);
      queue_ref(OP_REFERENCE, 16'h0001);
      queue_ref(OP_REFERENCE, 16'h8000);
      queue_ref(OP_REFERENCE, 16'h7FFF);
      drain_results();

      // Shrink the range: numbered nodes above it now read as out of range.
      set_node_count(17'd1);
      queue_ref(OP_REFERENCE, 16'h0001);
      queue_ref(OP_LOOKUP, 16'hFFFF);
      queue_ref(OP_REFERENCE, 16'h0000);
      queue_ref(OP_LOOKUP, 16'h0000);
      queue_ref(OP_REFERENCE, 16'hFFFF);
      drain_results();

      // Zero node count: everything is out of range for both ops.
      set_node_count(17'd0);
      queue_ref(OP_REFERENCE, 16'h0000);
      queue_ref(OP_LOOKUP, 16'h0000);
      drain_results();

      // One below full: top index out, next to top gets numbered.
      set_node_count(17'hFFFF);
      queue_ref(OP_REFERENCE, 16'hFFFF);
      queue_ref(OP_LOOKUP, 16'hFFFE);
      queue_ref(OP_REFERENCE, 16'hFFFE);
      queue_ref(OP_LOOKUP, 16'hFFFE);
      drain_results();

      // Random phases across several range settings.
      for (int p = 0; p < 7; p++) begin
         set_node_count(phase_limits[p]);
         idle_on = (p != 3);
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            queue_ref(($urandom_range(99) < 70) ? OP_REFERENCE : OP_LOOKUP, pick_node());
         // Hold off the receiver while the sender keeps offering, so the core backs up.
         if (p == 1)
            stall_ticket++;
         drain_results();
      end
      idle_on = 1'b1;

      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_numbers.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
